// ===== src/text_console_cursor_engine_macros.svh =====
// Assertion macros shared by the text console cursor engine RTL.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define TCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define TCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tcc_pkg.sv =====
// Shared types, codes and defaults for the text console cursor engine.
package tcc_pkg;

  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STOP_DEF = 8;

  localparam int OUT_ROW_W  = 5;
  localparam int OUT_COL_W  = 7;
  localparam int OUT_OFF_W  = 11;
  localparam int CELL_W     = 16;
  localparam int ADDR_EXT_W = 16;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_LAST_PRT  = 8'h7F;

  localparam logic [7:0]        RESET_COLOR = 8'h07;
  localparam logic [CELL_W-1:0] RESET_CELL  = 16'h0720;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  char_code;
    logic [10:0] read_address;
  } in_item_t;

  typedef struct packed {
    logic [OUT_ROW_W-1:0] cursor_row;
    logic [OUT_COL_W-1:0] cursor_column;
    logic [OUT_OFF_W-1:0] cursor_offset;
    logic [CELL_W-1:0]    cell_data;
  } out_item_t;

  // Decision of the cursor unit for one put-character beat.
  typedef struct packed {
    logic wr_en;
    logic scroll;
  } tcc_step_t;

endpackage

// ===== src/tcc_screen_ram.sv =====
// Screen cell store: one write port, one registered read port.
module tcc_screen_ram import tcc_pkg::*; #(
  parameter int DEPTH  = ROWS_DEF * COLUMNS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [CELL_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [CELL_W-1:0] rd_data
);

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/tcc_cursor.sv =====
// Cursor unit: decodes one character byte into a cell write and a cursor move.
module tcc_cursor import tcc_pkg::*; #(
  parameter int COLUMNS  = COLUMNS_DEF,
  parameter int ROWS     = ROWS_DEF,
  parameter int TAB_STOP = TAB_STOP_DEF,
  parameter int ROW_W    = $clog2(ROWS),
  parameter int COL_W    = $clog2(COLUMNS),
  parameter int ADDR_W   = $clog2(ROWS * COLUMNS)
) (
  input  logic [7:0]        char_code,
  input  logic [7:0]        text_color,
  input  logic [ROW_W-1:0]  row,
  input  logic [COL_W-1:0]  col,
  input  logic [ADDR_W-1:0] cur_off,
  output tcc_step_t         step,
  output logic [ROW_W-1:0]  row_nxt,
  output logic [COL_W-1:0]  col_nxt,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [CELL_W-1:0] wr_data
);

  localparam int TW = $clog2(COLUMNS + TAB_STOP);

  // Next tab stop for every column, built at elaboration.
  logic [TW-1:0] tab_tbl [COLUMNS];

  for (genvar g = 0; g < COLUMNS; g++) begin : g_tab
    assign tab_tbl[g] = TW'((g / TAB_STOP + 1) * TAB_STOP);
  end

  logic row_adv;
  logic wr_req;

  always_comb begin
    row_adv = 1'b0;
    col_nxt = col;
    wr_req  = 1'b0;
    wr_addr = cur_off;
    wr_data = {text_color, char_code};
    case (char_code)
      CH_BACKSPACE: begin
        if (col != '0) begin
          col_nxt = col - COL_W'(1);
          wr_req  = 1'b1;
          wr_addr = cur_off - ADDR_W'(1);
          wr_data = {text_color, CH_SPACE};
        end
      end
      CH_TAB: begin
        if (tab_tbl[col] >= TW'(COLUMNS)) begin
          col_nxt = '0;
          row_adv = 1'b1;
        end else begin
          col_nxt = COL_W'(tab_tbl[col]);
        end
      end
      CH_CR: begin
        col_nxt = '0;
      end
      CH_LF: begin
        col_nxt = '0;
        row_adv = 1'b1;
      end
      default: begin
        if (char_code inside {[CH_SPACE:CH_LAST_PRT]}) begin
          wr_req = 1'b1;
          if (col == COL_W'(COLUMNS - 1)) begin
            col_nxt = '0;
            row_adv = 1'b1;
          end else begin
            col_nxt = col + COL_W'(1);
          end
        end
      end
    endcase
  end

  // Past the bottom row: hold the row and ask for a scroll.
  always_comb begin
    row_nxt     = row;
    step.wr_en  = wr_req;
    step.scroll = 1'b0;
    if (row_adv) begin
      if (row == ROW_W'(ROWS - 1)) begin
        step.scroll = 1'b1;
      end else begin
        row_nxt = row + ROW_W'(1);
      end
    end
  end

endmodule

// ===== src/text_console_cursor_engine.sv =====
// Top level of the text console cursor engine: sequencer around the screen store.
//
// Usage. Present an item on in_item and raise start; it is taken at a rising edge
// with start high and busy low. Each item gives exactly one result beat on out_item,
// marked by out_strobe for one cycle; the receiver cannot stall it, so sample it
// then. The result carries the cursor after the item and, for a read, the cell.
// Write text_color via cfg_wr_en/cfg_wr_data only while busy is low; not enforced.
//
// Sequence, with N = ROWS*COLUMNS cells in the store (one write and one registered
// read port per cycle):
//   put without scroll, read, and undefined codes: execute state, then the strobe,
//     and the next item can be taken in the strobe cycle.
//   clear: after execute, N blank cells are written, one per cycle, then the strobe.
//   put that scrolls: after execute, rows move up one cell per cycle through the
//     read port (each cell is read, then written in the next cycle), then the
//     bottom row is blanked and the strobe follows.
// Reset: rst_n low for one edge starts a clearing pass that writes N cells with
// blank light grey on black; busy is high until the pass ends, with no result.
module text_console_cursor_engine import tcc_pkg::*; #(
  parameter int COLUMNS  = COLUMNS_DEF,
  parameter int ROWS     = ROWS_DEF,
  parameter int TAB_STOP = TAB_STOP_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item,
  input  logic      cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

`include "text_console_cursor_engine_macros.svh"

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_SCROLL = 2'd2;
  localparam logic [1:0] S_FILL   = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [7:0]        color_r;
  logic [ADDR_W-1:0] src_r, src_nxt;
  logic [ADDR_W-1:0] fill_ptr_r, fill_ptr_nxt;
  logic [CELL_W-1:0] fill_data_r, fill_data_nxt;
  logic              report_r, report_nxt;
  logic              cp_valid_r, cp_valid_nxt;
  logic [ADDR_W-1:0] cp_dst_r, cp_dst_nxt;
  logic              strobe_r, strobe_nxt;
  logic [CELL_W-1:0] out_cell_r, out_cell_nxt;

  // Accepted item, held for the execute cycle.
  logic [1:0]        op_r;
  logic [7:0]        char_r;
  logic              range_ok_r;

  logic                  accept;
  logic [ADDR_EXT_W-1:0] rd_addr_ext;
  logic [ADDR_W-1:0]     cur_off;
  logic [CELL_W-1:0]     blank;

  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [CELL_W-1:0] ram_wr_data;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [CELL_W-1:0] ram_rd_data;

  tcc_step_t         put_step;
  logic [ROW_W-1:0]  put_row;
  logic [COL_W-1:0]  put_col;
  logic [ADDR_W-1:0] put_addr;
  logic [CELL_W-1:0] put_data;

  assign busy        = (state_r != S_IDLE);
  assign accept      = start && !busy;
  assign rd_addr_ext = {{(ADDR_EXT_W - 11){1'b0}}, in_item.read_address};
  assign cur_off     = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
  assign blank       = {color_r, CH_SPACE};

  tcc_cursor #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP),
    .ROW_W    (ROW_W),
    .COL_W    (COL_W),
    .ADDR_W   (ADDR_W)
  ) u_cursor (
    .char_code  (char_r),
    .text_color (color_r),
    .row        (row_r),
    .col        (col_r),
    .cur_off    (cur_off),
    .step       (put_step),
    .row_nxt    (put_row),
    .col_nxt    (put_col),
    .wr_addr    (put_addr),
    .wr_data    (put_data)
  );

  // Read port: the item's address while idle, so the cell is ready in the execute
  // cycle; the scroll source otherwise.
  assign ram_rd_addr = (state_r == S_IDLE) ? rd_addr_ext[ADDR_W-1:0] : src_r;

  // Write port: put beat first, then a pending row copy, then the fill sweep.
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = fill_ptr_r;
    ram_wr_data = fill_data_r;
    if (state_r == S_EXEC && op_r == OP_PUT && put_step.wr_en) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = put_addr;
      ram_wr_data = put_data;
    end else if (cp_valid_r) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = cp_dst_r;
      ram_wr_data = ram_rd_data;
    end else if (state_r == S_FILL) begin
      ram_wr_en   = 1'b1;
    end
  end

  tcc_screen_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    src_nxt       = src_r;
    fill_ptr_nxt  = fill_ptr_r;
    fill_data_nxt = fill_data_r;
    report_nxt    = report_r;
    cp_valid_nxt  = (state_r == S_SCROLL);
    cp_dst_nxt    = src_r - ADDR_W'(COLUMNS);
    strobe_nxt    = 1'b0;
    out_cell_nxt  = out_cell_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        out_cell_nxt = '0;
        case (op_r)
          OP_PUT: begin
            row_nxt = put_row;
            col_nxt = put_col;
            if (put_step.scroll) begin
              state_nxt = S_SCROLL;
              src_nxt   = ADDR_W'(COLUMNS);
            end else begin
              state_nxt  = S_IDLE;
              strobe_nxt = 1'b1;
            end
          end
          OP_CLEAR: begin
            row_nxt       = '0;
            col_nxt       = '0;
            state_nxt     = S_FILL;
            fill_ptr_nxt  = '0;
            fill_data_nxt = blank;
            report_nxt    = 1'b1;
          end
          OP_READ: begin
            // Out-of-range addresses read as zero.
            out_cell_nxt = range_ok_r ? ram_rd_data : '0;
            state_nxt    = S_IDLE;
            strobe_nxt   = 1'b1;
          end
          default: begin
            state_nxt  = S_IDLE;
            strobe_nxt = 1'b1;
          end
        endcase
      end
      S_SCROLL: begin
        // Advance the copy source; the write of each cell follows in the next cycle.
        if (src_r == ADDR_W'(CELLS - 1)) begin
          state_nxt     = S_FILL;
          fill_ptr_nxt  = ADDR_W'(CELLS - COLUMNS);
          fill_data_nxt = blank;
          report_nxt    = 1'b1;
        end else begin
          src_nxt = src_r + ADDR_W'(1);
        end
      end
      S_FILL: begin
        // Hold the sweep while the last row copy owns the write port.
        if (!cp_valid_r) begin
          if (fill_ptr_r == ADDR_W'(CELLS - 1)) begin
            state_nxt  = S_IDLE;
            strobe_nxt = report_r;
          end else begin
            fill_ptr_nxt = fill_ptr_r + ADDR_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      row_r       <= '0;
      col_r       <= '0;
      color_r     <= RESET_COLOR;
      fill_ptr_r  <= '0;
      fill_data_r <= RESET_CELL;
      report_r    <= 1'b0;
      cp_valid_r  <= 1'b0;
      strobe_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      fill_ptr_r  <= fill_ptr_nxt;
      fill_data_r <= fill_data_nxt;
      report_r    <= report_nxt;
      cp_valid_r  <= cp_valid_nxt;
      strobe_r    <= strobe_nxt;
      if (cfg_wr_en) begin
        color_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    cp_dst_r   <= cp_dst_nxt;
    out_cell_r <= out_cell_nxt;
    if (accept) begin
      op_r       <= in_item.operation;
      char_r     <= in_item.char_code;
      range_ok_r <= (rd_addr_ext < ADDR_EXT_W'(CELLS));
    end
  end

  // Result beat: cursor registers are stable while the strobe is up.
  assign out_strobe             = strobe_r;
  assign out_item.cursor_row    = OUT_ROW_W'(row_r);
  assign out_item.cursor_column = OUT_COL_W'(col_r);
  assign out_item.cursor_offset = OUT_OFF_W'(cur_off);
  assign out_item.cell_data     = out_cell_r;

  `TCC_ASSERT_NOW(a_strobe_when_idle, out_strobe, !busy, "result beat while busy")
  `TCC_ASSERT_NEXT(a_accept_goes_busy, accept, busy && !out_strobe, "accept did not go busy")
  `TCC_ASSERT_NOW(a_cursor_in_range, 1'b1,
                  row_r <= ROW_W'(ROWS - 1) && col_r <= COL_W'(COLUMNS - 1),
                  "cursor outside the screen")
  `TCC_ASSERT_NOW(a_copy_in_sweep, cp_valid_r,
                  state_r == S_SCROLL || state_r == S_FILL,
                  "row copy pending outside a scroll")

endmodule

// ===== tb/sv/text_console_cursor_engine_test.sv =====
// Self-checking bench for the text console cursor engine: directed table, then random beats.
module text_console_cursor_engine_test;
  import tcc_pkg::*;

  localparam int CELLS = ROWS_DEF * COLUMNS_DEF;

  // The package names three operations; the fourth code must be ignored by the block.
  localparam logic [1:0] OP_UNDEFINED = 2'd3;

  localparam int RESET_CYCLES = 12;
  localparam int PHASES = 6;
  localparam int BEATS_PER_PHASE = 200;
  localparam int TAIL_CYCLES = 50;
  // Worst case: every beat scrolls plus the longest sender gap,
  // plus the clearing pass after reset; taken about three times over.
  localparam int CYCLE_LIMIT = 8_000_000;

  // Color register per phase: extremes and a few fixed mixes, then random settings.
  localparam logic [7:0] FIXED_COLORS [4] = '{8'h00, 8'hFF, 8'h1F, 8'hF0};
  // Sender idle percentage per phase; zero gives back-to-back beats.
  localparam int unsigned IDLE_PCT [PHASES] = '{0, 52, 20, 0, 52, 20};

  typedef struct {
    in_item_t  beat;
    bit        typed;
    out_item_t want;
  } directed_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_strobe;
  out_item_t out_item;
  logic      cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = '0;

  always #5 clk = ~clk;

  text_console_cursor_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Shadow of the console: cursor, color register and the whole screen store.
  int unsigned       shadow_row;
  int unsigned       shadow_col;
  logic [7:0]        shadow_color;
  logic [CELL_W-1:0] shadow_screen [CELLS];

  // Cursor reports still owed by the block, oldest first.
  out_item_t cursor_reports_due [$];
  int unsigned mismatches = 0;

  function automatic logic [CELL_W-1:0] blank_cell();
    return {shadow_color, CH_SPACE};
  endfunction

  // Advance the shadow console by one accepted beat and return the report it owes.
  function automatic out_item_t console_step(in_item_t it);
    out_item_t rep;
    int unsigned i;
    rep = '0;
    case (it.operation)
      OP_PUT: begin
        if (it.char_code == CH_BACKSPACE) begin
          // Backspace at the left edge changes nothing.
          if (shadow_col > 0) begin
            shadow_col--;
            shadow_screen[shadow_row * COLUMNS_DEF + shadow_col] = blank_cell();
          end
        end else if (it.char_code == CH_TAB) begin
          // Always strictly forward to the next tab stop.
          shadow_col = shadow_col + TAB_STOP_DEF - shadow_col % TAB_STOP_DEF;
        end else if (it.char_code == CH_CR) begin
          shadow_col = 0;
        end else if (it.char_code == CH_LF) begin
          shadow_col = 0;
          shadow_row++;
        end else if (it.char_code >= CH_SPACE && it.char_code <= CH_LAST_PRT) begin
          shadow_screen[shadow_row * COLUMNS_DEF + shadow_col] = {shadow_color, it.char_code};
          shadow_col++;
        end
        // Other control bytes and the upper half of the byte range fall through here.
        if (shadow_col >= COLUMNS_DEF) begin
          shadow_col = 0;
          shadow_row++;
        end
        // Ran off the bottom: move everything up one row, blank the last row.
        if (shadow_row >= ROWS_DEF) begin
          for (i = 0; i < CELLS - COLUMNS_DEF; i++)
            shadow_screen[i] = shadow_screen[i + COLUMNS_DEF];
          for (i = CELLS - COLUMNS_DEF; i < CELLS; i++)
            shadow_screen[i] = blank_cell();
          shadow_row--;
        end
      end
      OP_CLEAR: begin
        // Row 0 is blanked too.
        foreach (shadow_screen[j]) shadow_screen[j] = blank_cell();
        shadow_row = 0;
        shadow_col = 0;
      end
      OP_READ: begin
        // Out-of-range addresses read as zero; the store is left alone.
        if (it.read_address < CELLS) rep.cell_data = shadow_screen[it.read_address];
      end
      default: ;
    endcase
    rep.cursor_row    = shadow_row[OUT_ROW_W-1:0];
    rep.cursor_column = shadow_col[OUT_COL_W-1:0];
    rep.cursor_offset = OUT_OFF_W'(shadow_row * COLUMNS_DEF + shadow_col);
    return rep;
  endfunction

  // Rows whose report is typed in always have the cursor at home, so only the cell is given.
  function automatic directed_row_t make_row(logic [1:0] op, logic [7:0] ch,
                                             logic [10:0] addr, bit typed,
                                             logic [CELL_W-1:0] cell_val);
    directed_row_t r;
    r.beat.operation    = op;
    r.beat.char_code    = ch;
    r.beat.read_address = addr;
    r.typed             = typed;
    r.want              = '0;
    r.want.cell_data    = cell_val;
    return r;
  endfunction

  // Random beat, weighted toward text that fills lines and pushes the cursor to the
  // bottom so that wraps and scrolls happen often; clears are rare so rows accumulate.
  function automatic in_item_t random_beat();
    in_item_t it;
    int unsigned pick;
    int unsigned base;
    int unsigned back;
    it.operation    = OP_PUT;
    it.char_code    = 8'($urandom_range(255));
    it.read_address = 11'($urandom_range(2047));
    pick = $urandom_range(999);
    base = shadow_row * COLUMNS_DEF + shadow_col;
    if (pick < 500) begin
      it.char_code = 8'($urandom_range(CH_SPACE, CH_LAST_PRT));
    end else if (pick < 550) begin
      it.char_code = CH_BACKSPACE;
    end else if (pick < 600) begin
      it.char_code = CH_TAB;
    end else if (pick < 630) begin
      it.char_code = CH_CR;
    end else if (pick < 710) begin
      it.char_code = CH_LF;
    end else if (pick < 760) begin
      // Noise: any byte, mostly ignored control and high codes.
      it.char_code = 8'($urandom_range(255));
    end else if (pick < 957) begin
      it.operation = OP_READ;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          // Look just behind the cursor, where fresh text and scrolled rows sit.
          back = $urandom_range(base < 160 ? base : 160);
          it.read_address = 11'(base - back);
        end
        9:       it.read_address = 11'($urandom_range(CELLS, 2047));
        default: it.read_address = 11'($urandom_range(CELLS - 1));
      endcase
    end else if (pick < 960) begin
      it.operation = OP_CLEAR;
    end else begin
      it.operation = OP_UNDEFINED;
    end
    return it;
  endfunction

  // Hold the beat until taken (start high, busy low at the edge), then log its report.
  // A gap drops start once; without a gap start simply stays high for the next beat.
  task automatic send_beat(input in_item_t it, input bit typed, input out_item_t want,
                           input int unsigned idle_pct);
    out_item_t predicted;
    int unsigned gap;
    in_item <= it;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = console_step(it);
    cursor_reports_due.push_back(typed ? want : predicted);
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending, wait for every owed report and an idle block, then load the color.
  task automatic drain_and_set_color(input logic [7:0] color);
    start <= 1'b0;
    while (cursor_reports_due.size() != 0 || busy) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= color;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_color = color;
  endtask

  // Result side: the receiver cannot stall, so every strobe is a beat to check.
  always @(posedge clk) begin : report_check
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (cursor_reports_due.size() == 0) begin
        $error("result beat with nothing owed: row %0d column %0d cell %h",
               out_item.cursor_row, out_item.cursor_column, out_item.cell_data);
        mismatches++;
      end else begin
        want = cursor_reports_due.pop_front();
        if (out_item.cursor_row !== want.cursor_row) begin
          $error("cursor_row: expected %0d, got %0d", want.cursor_row, out_item.cursor_row);
          mismatches++;
        end
        if (out_item.cursor_column !== want.cursor_column) begin
          $error("cursor_column: expected %0d, got %0d",
                 want.cursor_column, out_item.cursor_column);
          mismatches++;
        end
        if (out_item.cursor_offset !== want.cursor_offset) begin
          $error("cursor_offset: expected %0d, got %0d",
                 want.cursor_offset, out_item.cursor_offset);
          mismatches++;
        end
        if (out_item.cell_data !== want.cell_data) begin
          $error("cell_data: expected %h, got %h", want.cell_data, out_item.cell_data);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $error("cycle limit reached with %0d reports owed", cursor_reports_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    directed_row_t rows [$];
    directed_row_t r;
    int unsigned p;
    int unsigned n;
    logic [7:0] color;

    shadow_row   = 0;
    shadow_col   = 0;
    shadow_color = RESET_COLOR;
    foreach (shadow_screen[i]) shadow_screen[i] = RESET_CELL;

    // Reset cells and range edges of the read address, with the cursor still at home.
    rows.push_back(make_row(OP_READ,      8'h00, 11'd0,    1'b1, RESET_CELL));
    rows.push_back(make_row(OP_READ,      8'hFF, 11'd1999, 1'b1, RESET_CELL));
    rows.push_back(make_row(OP_READ,      8'h00, 11'd2000, 1'b1, '0));
    rows.push_back(make_row(OP_READ,      8'h00, 11'd2047, 1'b1, '0));
    // Undefined operation: cursor reported, no cell.
    rows.push_back(make_row(OP_UNDEFINED, 8'hFF, 11'd2047, 1'b1, '0));
    // Backspace at column zero leaves everything as is.
    rows.push_back(make_row(OP_PUT, CH_BACKSPACE, 11'd0, 1'b1, '0));
    // Printable range edges, then backspace blanking with the reset color, reads and tabs.
    rows.push_back(make_row(OP_PUT, CH_SPACE,    11'd0,    1'b0, '0));
    rows.push_back(make_row(OP_PUT, 8'h41,       11'd0,    1'b0, '0));
    rows.push_back(make_row(OP_PUT, CH_LAST_PRT, 11'd2047, 1'b0, '0));
    rows.push_back(make_row(OP_PUT, CH_BACKSPACE, 11'd0,   1'b0, '0));
    rows.push_back(make_row(OP_READ, 8'h00, 11'd1, 1'b0, '0));
    rows.push_back(make_row(OP_READ, 8'h00, 11'd2, 1'b0, '0));
    rows.push_back(make_row(OP_PUT, CH_TAB, 11'd0, 1'b0, '0));
    rows.push_back(make_row(OP_PUT, CH_TAB, 11'd0, 1'b0, '0));
    // Ignored bytes: low controls and the upper half of the byte range; then CR, LF, a read.
    rows.push_back(make_row(OP_PUT, 8'h00, 11'd0, 1'b0, '0));
    rows.push_back(make_row(OP_PUT, 8'h1F, 11'd0, 1'b0, '0));
    rows.push_back(make_row(OP_PUT, 8'h80, 11'd0, 1'b0, '0));
    rows.push_back(make_row(OP_PUT, 8'hFF, 11'd0, 1'b0, '0));
    rows.push_back(make_row(OP_PUT, 8'h0B, 11'd0, 1'b0, '0));
    rows.push_back(make_row(OP_PUT, CH_CR, 11'd0, 1'b0, '0));
    rows.push_back(make_row(OP_PUT, CH_LF, 11'd0, 1'b0, '0));
    rows.push_back(make_row(OP_READ, 8'h00, 11'd0, 1'b0, '0));
    // Clear homes the cursor; the following read shows row 0 blanked as well.
    rows.push_back(make_row(OP_CLEAR, 8'h00, 11'd0, 1'b1, '0));
    rows.push_back(make_row(OP_READ,  8'h00, 11'd1, 1'b0, '0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats run with the reset color, back to back; busy holds the first
    // one off until the clearing pass after reset is done.
    foreach (rows[k]) begin
      r = rows[k];
      send_beat(r.beat, r.typed, r.want, 0);
    end

    // Each phase drains the block, loads a new color and sends random beats
    // with its own sender idle rate.
    for (p = 0; p < PHASES; p++) begin
      color = (p < 4) ? FIXED_COLORS[p] : 8'($urandom_range(255));
      drain_and_set_color(color);
      for (n = 0; n < BEATS_PER_PHASE; n++)
        send_beat(random_beat(), 1'b0, '0, IDLE_PCT[p]);
    end

    start <= 1'b0;
    while (cursor_reports_due.size() != 0) @(posedge clk);
    // Watch a little longer for stray strobes.
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
